/* sv/aalc_pkg.sv */
// Shared constants, codes and control types of the address allow-list check.
`default_nettype none

package aalc_pkg;

	// Table sizes.
	localparam int V4_ENTRIES = 64;
	localparam int V6_ENTRIES = 64;

	// Slot address widths and fill count widths (a fill count can hold the depth).
	localparam int V4_AW = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
	localparam int V6_AW = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
	localparam int V4_CW = $clog2(V4_ENTRIES + 1);
	localparam int V6_CW = $clog2(V6_ENTRIES + 1);
	localparam int SCAN_W = (V4_CW > V6_CW) ? V4_CW : V6_CW;

	// Item operation codes.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_CHECK  = 1'b1;

	// Address family codes.
	localparam logic [1:0] FAM_V4 = 2'd0;
	localparam logic [1:0] FAM_V6 = 2'd1;

	// Upper word of the low half for an IPv4-mapped IPv6 address.
	localparam logic [31:0] MAPPED_TAG = 32'h0000_ffff;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_PRESENT = 2'd1,
		ST_FULL    = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_unknown;
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

/* sv/aalc_req_if.sv */
// Request channel interface: one address item per beat.
`default_nettype none

interface aalc_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [1:0]  family;
	logic [63:0] addr_high;
	logic [63:0] addr_low;

	modport source (output valid, func, family, addr_high, addr_low, input ready);
	modport sink (input valid, func, family, addr_high, addr_low, output ready);
endinterface

`default_nettype wire

/* sv/aalc_rsp_if.sv */
// Response channel interface: one result per beat.
`default_nettype none

interface aalc_rsp_if;
	logic       valid;
	logic       ready;
	logic       allowed;
	logic [1:0] status;

	modport source (output valid, allowed, status, input ready);
	modport sink (input valid, allowed, status, output ready);
endinterface

`default_nettype wire

/* sv/aalc_ctrl.sv */
// Controller state machine: sequences load, table scan, finish and response.
`default_nettype none

module aalc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire aalc_pkg::stat_t stat,
	output aalc_pkg::cmd_t      cmd
);

	aalc_pkg::state_t state_q;
	aalc_pkg::state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aalc_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			aalc_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = stat.in_unknown ? aalc_pkg::S_RESP : aalc_pkg::S_SCAN;
				end
			end
			aalc_pkg::S_SCAN: begin
				if (stat.scan_done) begin
					state_nxt = aalc_pkg::S_RESP;
				end
			end
			aalc_pkg::S_RESP: begin
				if (stat.out_free) begin
					state_nxt = aalc_pkg::S_IDLE;
				end
			end
			default: state_nxt = aalc_pkg::S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			aalc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			aalc_pkg::S_SCAN: begin
				cmd.scan   = !stat.scan_done;
				cmd.finish = stat.scan_done;
			end
			aalc_pkg::S_RESP: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// A scan is only ever started for a known family.
	property p_scan_known;
		@(posedge clk) disable iff (!arst_n)
		(cmd.load && !stat.in_unknown) |=> (state_q == aalc_pkg::S_SCAN);
	endproperty
	a_scan_known: assert property (p_scan_known) else $error("scan not started after load");

	// An unknown family goes straight to the response.
	property p_unknown_resp;
		@(posedge clk) disable iff (!arst_n)
		(cmd.load && stat.in_unknown) |=> (state_q == aalc_pkg::S_RESP);
	endproperty
	a_unknown_resp: assert property (p_unknown_resp) else $error("unknown family not answered");

	// Finish and emit, and load and scan, are never issued together.
	property p_cmd_excl;
		@(posedge clk) disable iff (!arst_n)
		!(cmd.finish && cmd.emit) && !(cmd.load && cmd.scan);
	endproperty
	a_cmd_excl: assert property (p_cmd_excl) else $error("conflicting commands");

endmodule

`default_nettype wire

/* sv/aalc_dp.sv */
// Datapath: item registers, address tables, fill counts, scan and result registers.
`default_nettype none

module aalc_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire aalc_pkg::cmd_t  cmd,
	output aalc_pkg::stat_t      stat,
	input  wire logic            in_func,
	input  wire logic [1:0]      in_family,
	input  wire logic [63:0]     in_addr_high,
	input  wire logic [63:0]     in_addr_low,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic                 out_allowed,
	output logic [1:0]           out_status
);

	// Item registers.
	logic        func_q;
	logic        use_v4_q;
	logic [63:0] key_high_q;
	logic [63:0] key_low_q;

	// Fill counts and scan state.
	logic [aalc_pkg::V4_CW-1:0]  v4_fill_q;
	logic [aalc_pkg::V6_CW-1:0]  v6_fill_q;
	logic [aalc_pkg::SCAN_W-1:0] idx_q;
	logic [aalc_pkg::SCAN_W-1:0] limit;
	logic                        rd_vld_s1;
	logic                        hit_q;
	logic                        hit_now;
	logic                        issue;

	// Tables and their registered read data.
	logic [31:0]  v4_mem [aalc_pkg::V4_ENTRIES];
	logic [127:0] v6_mem [aalc_pkg::V6_ENTRIES];
	logic [31:0]  v4_rd_s1;
	logic [127:0] v6_rd_s1;

	// Result holding and output registers.
	logic                  res_allowed_q;
	aalc_pkg::status_t     res_status_q;
	logic                  out_valid_q;
	logic                  out_allowed_q;
	logic [1:0]            out_status_q;

	logic in_unknown;
	logic in_mapped;
	logic v4_full;
	logic v6_full;
	logic wr_v4;
	logic wr_v6;

	// Decode of the incoming beat.
	assign in_unknown = (in_family != aalc_pkg::FAM_V4) && (in_family != aalc_pkg::FAM_V6);
	assign in_mapped  = (in_addr_high == 64'd0) && (in_addr_low[63:32] == aalc_pkg::MAPPED_TAG);

	// Scan bound, issue and compare of the previous read.
	assign limit   = use_v4_q ? aalc_pkg::SCAN_W'(v4_fill_q) : aalc_pkg::SCAN_W'(v6_fill_q);
	assign issue   = cmd.scan && (idx_q < limit);
	assign hit_now = rd_vld_s1 && (use_v4_q ? (v4_rd_s1 == key_low_q[31:0])
	                                        : (v6_rd_s1 == {key_high_q, key_low_q}));

	// Table full flags and write enables at finish of an insert.
	assign v4_full = (v4_fill_q == aalc_pkg::V4_CW'(aalc_pkg::V4_ENTRIES));
	assign v6_full = (v6_fill_q == aalc_pkg::V6_CW'(aalc_pkg::V6_ENTRIES));
	assign wr_v4 = cmd.finish && (func_q == aalc_pkg::FUNC_INSERT) && !hit_q
	               && use_v4_q && !v4_full;
	assign wr_v6 = cmd.finish && (func_q == aalc_pkg::FUNC_INSERT) && !hit_q
	               && !use_v4_q && !v6_full;

	// Status to the controller.
	assign stat.in_unknown = in_unknown;
	assign stat.scan_done  = hit_q || ((idx_q >= limit) && !rd_vld_s1);
	assign stat.out_free   = !out_valid_q || out_ready;

	// Item registers, loaded on an accepted beat.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= in_func;
			use_v4_q   <= (in_family == aalc_pkg::FAM_V4)
			              || ((in_func == aalc_pkg::FUNC_CHECK) && in_mapped);
			key_high_q <= in_addr_high;
			key_low_q  <= in_addr_low;
		end
	end

	// Scan counter, read valid pipeline and sticky hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.load) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			hit_q     <= hit_q || hit_now;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Fill counts grow by one on each stored address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_fill_q <= '0;
			v6_fill_q <= '0;
		end else begin
			if (wr_v4) begin
				v4_fill_q <= v4_fill_q + 1'b1;
			end
			if (wr_v6) begin
				v6_fill_q <= v6_fill_q + 1'b1;
			end
		end
	end

	// IPv4 table: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (wr_v4) begin
			v4_mem[v4_fill_q[aalc_pkg::V4_AW-1:0]] <= key_low_q[31:0];
		end
		v4_rd_s1 <= v4_mem[idx_q[aalc_pkg::V4_AW-1:0]];
	end

	// IPv6 table: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (wr_v6) begin
			v6_mem[v6_fill_q[aalc_pkg::V6_AW-1:0]] <= {key_high_q, key_low_q};
		end
		v6_rd_s1 <= v6_mem[idx_q[aalc_pkg::V6_AW-1:0]];
	end

	// Result of the item in flight.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_allowed_q <= 1'b0;
			res_status_q  <= in_unknown ? aalc_pkg::ST_UNKNOWN : aalc_pkg::ST_DONE;
		end else if (cmd.finish) begin
			if (func_q == aalc_pkg::FUNC_CHECK) begin
				res_allowed_q <= hit_q;
				res_status_q  <= aalc_pkg::ST_DONE;
			end else if (hit_q) begin
				res_status_q <= aalc_pkg::ST_PRESENT;
			end else if (use_v4_q ? v4_full : v6_full) begin
				res_status_q <= aalc_pkg::ST_FULL;
			end else begin
				res_status_q <= aalc_pkg::ST_DONE;
			end
		end
	end

	// Output register: holds a beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_allowed_q <= res_allowed_q;
			out_status_q  <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_allowed = out_allowed_q;
	assign out_status  = out_status_q;

	// Fill counts never pass the table depth.
	property p_fill_bound;
		@(posedge clk) disable iff (!arst_n)
		(v4_fill_q <= aalc_pkg::V4_CW'(aalc_pkg::V4_ENTRIES))
		&& (v6_fill_q <= aalc_pkg::V6_CW'(aalc_pkg::V6_ENTRIES));
	endproperty
	a_fill_bound: assert property (p_fill_bound) else $error("fill count past depth");

	// A stored IPv4 address raises its fill count by exactly one.
	property p_v4_grow;
		@(posedge clk) disable iff (!arst_n)
		wr_v4 |=> (v4_fill_q == $past(v4_fill_q) + 1'b1);
	endproperty
	a_v4_grow: assert property (p_v4_grow) else $error("IPv4 fill count did not advance");

	// A new result is never loaded over one that has not been taken.
	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready);
	endproperty
	a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

	// A hit is only seen on a read that was issued below the fill count.
	property p_hit_read;
		@(posedge clk) disable iff (!arst_n)
		hit_now |-> $past(issue);
	endproperty
	a_hit_read: assert property (p_hit_read) else $error("hit without a valid read");

endmodule

`default_nettype wire

/* sv/address_allow_list_check_core.sv */
// Top level of the address allow-list check: controller and datapath.
//
//  channel | dir | beat content
//  --------+-----+--------------------------------------------
//  req     | in  | func, family, addr_high, addr_low
//  rsp     | out | allowed, status
//
// An item scans the table that is searched up to its fill count: the tables are
// memories with one registered read a cycle, so the scan compares one stored
// address per cycle. A hit ends the scan early, and an unknown family skips the
// scan. Items are taken one at a time.
// Reset clears both fill counts at once; table contents need no clearing.
// A stalled response holds in the output register while the next item is taken.
`default_nettype none

module address_allow_list_check_core (
	input wire logic clk,
	input wire logic arst_n,
	aalc_req_if.sink   req,
	aalc_rsp_if.source rsp
);

	aalc_pkg::cmd_t  cmd;
	aalc_pkg::stat_t stat;
	logic            in_ready;

	aalc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	aalc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_func      (req.func),
		.in_family    (req.family),
		.in_addr_high (req.addr_high),
		.in_addr_low  (req.addr_low),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_allowed  (rsp.allowed),
		.out_status   (rsp.status)
	);

	assign req.ready = in_ready;

endmodule

`default_nettype wire

/* tb/aalc_checker.sv */
// Checker for the address allow-list check: predicts each result and compares the response beats.
`timescale 1ns / 100ps
`default_nettype none

module aalc_checker
	import aalc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	aalc_req_if      req,
	aalc_rsp_if      rsp,
	output int       fail_count,
	output int       open_results,
	output int       allowed_seen,
	output int       present_seen,
	output int       full_seen,
	output int       unknown_seen
);

	// One predicted response beat.
	typedef struct {
		logic    allowed;
		status_t status;
	} verdict_t;

	// Private copy of both allow-list tables and their fill counts.
	logic [31:0]  v4_slots [V4_ENTRIES];
	logic [127:0] v6_slots [V6_ENTRIES];
	int           v4_used;
	int           v6_used;

	verdict_t pending_verdicts[$];
	int       errors;
	int       n_allowed, n_present, n_full, n_unknown;

	function automatic logic v4_listed(input logic [31:0] addr);
		for (int i = 0; i < v4_used; i++) begin
			if (v4_slots[i] == addr)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic v6_listed(input logic [127:0] addr);
		for (int i = 0; i < v6_used; i++) begin
			if (v6_slots[i] == addr)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Work out the answer to one request and update the tables on an insert.
	function automatic verdict_t lookup_or_insert(input logic fn, input logic [1:0] fam,
			input logic [63:0] hi, input logic [63:0] lo);
		verdict_t v;
		logic     mapped;
		v.allowed = 1'b0;
		v.status  = ST_DONE;
		mapped = (hi == 64'd0) && (lo[63:32] == MAPPED_TAG);
		if (fam != FAM_V4 && fam != FAM_V6) begin
			v.status = ST_UNKNOWN;
		end else if (fn == FUNC_CHECK) begin
			// A mapped IPv6 address is answered from the IPv4 table.
			if (fam == FAM_V4 || mapped)
				v.allowed = v4_listed(lo[31:0]);
			else
				v.allowed = v6_listed({hi, lo});
		end else if (fam == FAM_V4) begin
			if (v4_listed(lo[31:0])) begin
				v.status = ST_PRESENT;
			end else if (v4_used >= V4_ENTRIES) begin
				v.status = ST_FULL;
			end else begin
				v4_slots[v4_used] = lo[31:0];
				v4_used++;
			end
		end else begin
			// Mapped addresses sent as IPv6 are stored as they are.
			if (v6_listed({hi, lo})) begin
				v.status = ST_PRESENT;
			end else if (v6_used >= V6_ENTRIES) begin
				v.status = ST_FULL;
			end else begin
				v6_slots[v6_used] = {hi, lo};
				v6_used++;
			end
		end
		return v;
	endfunction

	// Compare response beats first, then queue the prediction for a new request beat.
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			pending_verdicts.delete();
			v4_used = 0;
			v6_used = 0;
			errors = 0;
			n_allowed = 0;
			n_present = 0;
			n_full = 0;
			n_unknown = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t: response beat with nothing expected: allowed=%0b status=%0d",
						$time, rsp.allowed, rsp.status);
					errors++;
				end else begin
					want = pending_verdicts.pop_front();
					if (rsp.allowed !== want.allowed) begin
						$display("%0t: allowed mismatch: expected %0b, actual %0b",
							$time, want.allowed, rsp.allowed);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, rsp.status);
						errors++;
					end
					if (want.allowed)
						n_allowed++;
					case (want.status)
						ST_PRESENT: n_present++;
						ST_FULL:    n_full++;
						ST_UNKNOWN: n_unknown++;
						default:    ;
					endcase
				end
			end
			if (req.valid && req.ready) begin
				got = lookup_or_insert(req.func, req.family, req.addr_high, req.addr_low);
				pending_verdicts.insert(pending_verdicts.size(), got);
			end
		end
		fail_count   <= errors;
		open_results <= pending_verdicts.size();
		allowed_seen <= n_allowed;
		present_seen <= n_present;
		full_seen    <= n_full;
		unknown_seen <= n_unknown;
	end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Top of the address allow-list check testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none

module tb;
	import aalc_pkg::*;

	// Family codes outside IPv4 and IPv6.
	localparam logic [1:0] FAM_OTHER    = 2'd2;
	localparam logic [1:0] FAM_RESERVED = 2'd3;

	localparam int RANDOM_ITEMS = 1030;
	localparam int STRETCH_LEN  = 80;
	localparam int STALL_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 80;

	logic clk = 1'b0;
	logic arst_n;

	aalc_req_if req ();
	aalc_rsp_if rsp ();

	int fail_count, open_results;
	int allowed_seen, present_seen, full_seen, unknown_seen;
	int items_sent;
	int idle_cycles = 0;
	bit quiet_stretch;

	// Addresses already offered for insertion, reused to reach hits and duplicates.
	logic [31:0]  v4_pool[$];
	logic [127:0] v6_pool[$];

	address_allow_list_check_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	aalc_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.open_results(open_results),
		.allowed_seen(allowed_seen),
		.present_seen(present_seen),
		.full_seen   (full_seen),
		.unknown_seen(unknown_seen)
	);

	always #10 clk = ~clk;

	function automatic int draw_wait();
		return quiet_stretch ? 0 : $urandom_range(0, 14);
	endfunction

	// Send one request beat after a random gap, optionally draining all results first.
	task automatic push_item(input logic fn, input logic [1:0] fam,
			input logic [63:0] hi, input logic [63:0] lo, input bit drain);
		int gap;
		gap = draw_wait();
		if (gap > 0 || drain) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			if (drain) begin
				@(posedge clk);
				while (open_results != 0)
					@(posedge clk);
			end
		end
		req.valid     <= 1'b1;
		req.func      <= fn;
		req.family    <= fam;
		req.addr_high <= hi;
		req.addr_low  <= lo;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		items_sent++;
		if (fn == FUNC_INSERT && fam == FAM_V4)
			v4_pool.insert(v4_pool.size(), lo[31:0]);
		else if (fn == FUNC_INSERT && fam == FAM_V6)
			v6_pool.insert(v6_pool.size(), {hi, lo});
	endtask

	// Response side: random stall before each beat.
	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid)
				@(posedge clk);
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d cycles without a beat.", idle_cycles);
				$display("address_allow_list_check_core verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int          r, c;
		logic        fn;
		logic [1:0]  fam;
		logic [63:0] hi, lo;
		logic [31:0] v4;

		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.func      = FUNC_INSERT;
		req.family    = FAM_V4;
		req.addr_high = 64'd0;
		req.addr_low  = 64'd0;
		rsp.ready     = 1'b0;
		items_sent    = 0;
		quiet_stretch = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, duplicates, ignored upper bits, extremes,
		// mapped lookups, a mapped address stored as IPv6, and unknown families.
		push_item(FUNC_CHECK,  FAM_V4, 64'd0, 64'd0, 1'b0);
		push_item(FUNC_INSERT, FAM_V4, 64'd0, 64'd0, 1'b0);
		push_item(FUNC_INSERT, FAM_V4, 64'd0, 64'd0, 1'b0);
		push_item(FUNC_INSERT, FAM_V4, '1, '1, 1'b0);
		push_item(FUNC_CHECK,  FAM_V4, 64'd0, {32'd0, 32'hffff_ffff}, 1'b0);
		push_item(FUNC_INSERT, FAM_V6, 64'd0, 64'd0, 1'b0);
		push_item(FUNC_INSERT, FAM_V6, '1, '1, 1'b0);
		push_item(FUNC_CHECK,  FAM_V6, '1, '1, 1'b0);
		push_item(FUNC_CHECK,  FAM_V6, '1, 64'd0, 1'b0);
		push_item(FUNC_CHECK,  FAM_V6, 64'd0, {MAPPED_TAG, 32'hffff_ffff}, 1'b0);
		push_item(FUNC_INSERT, FAM_V6, 64'd0, {MAPPED_TAG, 32'h0102_0304}, 1'b0);
		push_item(FUNC_CHECK,  FAM_V6, 64'd0, {MAPPED_TAG, 32'h0102_0304}, 1'b0);
		push_item(FUNC_CHECK,  FAM_V4, 64'd0, {32'd0, 32'h0102_0304}, 1'b0);
		push_item(FUNC_INSERT, FAM_V6, 64'd0, {MAPPED_TAG, 32'h0102_0304}, 1'b0);
		push_item(FUNC_CHECK,  FAM_V6, 64'd1, {MAPPED_TAG, 32'hffff_ffff}, 1'b0);
		push_item(FUNC_CHECK,  FAM_V6, 64'd0, {32'h0000_fffe, 32'hffff_ffff}, 1'b0);
		push_item(FUNC_INSERT, FAM_OTHER, 64'd0, {32'd0, 32'h0a00_0001}, 1'b0);
		push_item(FUNC_INSERT, FAM_RESERVED, '1, '1, 1'b0);
		push_item(FUNC_CHECK,  FAM_OTHER, '1, '1, 1'b0);
		push_item(FUNC_CHECK,  FAM_RESERVED, 64'd0, 64'd0, 1'b0);

		// Random part: reused addresses for hits and duplicates, fresh ones to fill
		// both tables, mapped and near-mapped forms, and a few unknown families.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % STRETCH_LEN == 0)
				quiet_stretch = ($urandom_range(0, 3) == 0);
			fn = $urandom_range(0, 1) ? FUNC_CHECK : FUNC_INSERT;
			r = $urandom_range(0, 99);
			fam = (r < 45) ? FAM_V4 : (r < 92) ? FAM_V6 : (r < 96) ? FAM_OTHER : FAM_RESERVED;
			if (v4_pool.size() > 0 && $urandom_range(0, 1))
				v4 = v4_pool[$urandom_range(0, v4_pool.size() - 1)];
			else
				v4 = $urandom;
			if (fam == FAM_V4) begin
				hi = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
				lo = {($urandom_range(0, 3) == 0) ? $urandom : 32'd0, v4};
			end else begin
				c = $urandom_range(0, 9);
				if (c < 4 && v6_pool.size() > 0) begin
					{hi, lo} = v6_pool[$urandom_range(0, v6_pool.size() - 1)];
				end else if (c < 7) begin
					hi = 64'd0;
					lo = {MAPPED_TAG, v4};
				end else if (c == 7) begin
					hi = 64'd0;
					lo = {$urandom, $urandom};
				end else begin
					hi = {$urandom, $urandom};
					lo = {$urandom, $urandom};
				end
			end
			push_item(fn, fam, hi, lo, n == RANDOM_ITEMS / 2);
		end
		req.valid <= 1'b0;

		// Let the checker count the last beat before waiting for the results.
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d allowed answers, %0d duplicate inserts,",
			items_sent, allowed_seen, present_seen);
		$display("%0d table-full drops and %0d unknown-family items, with random gaps.",
			full_seen, unknown_seen);
		if (fail_count == 0 && open_results == 0)
			$display("address_allow_list_check_core verification clean");
		else
			$display("address_allow_list_check_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire

/* address_allow_list_check_core.f */
sv/aalc_pkg.sv
sv/aalc_req_if.sv
sv/aalc_rsp_if.sv
sv/aalc_ctrl.sv
sv/aalc_dp.sv
sv/address_allow_list_check_core.sv
tb/aalc_checker.sv
tb/tb.sv
